@@ design/rtpts_pkg.sv @@
package rtpts_pkg;

    localparam int TS_PACKET_BYTES = 188;
    localparam int HEADER_BYTES    = 12;
    localparam int MTU_OVERHEAD    = 14;
    localparam int MTU_W           = 11;
    localparam int PT_W            = 7;
    localparam int SEQ_W           = 16;
    localparam int TS_W            = 32;
    localparam int IDX_W           = $clog2(HEADER_BYTES);
    localparam int HDR_W           = 8 * HEADER_BYTES;
    localparam int MTU_MAX         = 2 ** MTU_W - 1;
    localparam int PS_MAX_K        = (MTU_MAX - MTU_OVERHEAD) / TS_PACKET_BYTES;
    localparam int APB_AW          = 4;

    localparam logic [MTU_W-1:0] MTU_RST  = MTU_W'(1500);
    localparam logic [PT_W-1:0]  PT_RST   = PT_W'(33);
    localparam logic [31:0]      SSRC_RST = 32'd12;
    localparam logic [7:0]       RTP_BYTE0  = 8'h80;
    localparam logic [31:0]      TS_WRAP    = 32'hFFFF_FFFF;
    localparam logic [TS_W-1:0]  TS_SCALE   = TS_W'(90);

    localparam logic [1:0] REG_MTU  = 2'd0;
    localparam logic [1:0] REG_PT   = 2'd1;
    localparam logic [1:0] REG_SSRC = 2'd2;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_READY,
        ST_HDR,
        ST_PAY
    } t_state;

    typedef struct packed {
        logic [PT_W-1:0]  payload_type;
        logic [31:0]      ssrc_id;
        logic [MTU_W-1:0] psize;
    } t_cfg;

    function automatic logic [MTU_W-1:0] pay_size(input logic [MTU_W-1:0] mtu);
        logic [MTU_W-1:0] p;
        p = MTU_W'(TS_PACKET_BYTES);
        for (int k = 2; k <= PS_MAX_K; k++) begin
            if (mtu >= MTU_W'(MTU_OVERHEAD + TS_PACKET_BYTES * k))
                p = MTU_W'(TS_PACKET_BYTES * k);
        end
        return p;
    endfunction

endpackage

@@ design/rtpts_cfg.sv @@
module rtpts_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtpts_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rtpts_pkg::t_cfg              o_cfg
);

    logic [rtpts_pkg::MTU_W-1:0] r_mtu;
    logic [rtpts_pkg::PT_W-1:0]  r_pt;
    logic [31:0]                 r_ssrc;
    logic [rtpts_pkg::MTU_W-1:0] r_psize;
    logic                        wr_en;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu   <= rtpts_pkg::MTU_RST;
            r_pt    <= rtpts_pkg::PT_RST;
            r_ssrc  <= rtpts_pkg::SSRC_RST;
            r_psize <= rtpts_pkg::pay_size(rtpts_pkg::MTU_RST);
        end else if (wr_en) begin
            case (reg_idx)
                rtpts_pkg::REG_MTU: begin
                    r_mtu   <= pwdata[rtpts_pkg::MTU_W-1:0];
                    r_psize <= rtpts_pkg::pay_size(pwdata[rtpts_pkg::MTU_W-1:0]);
                end
                rtpts_pkg::REG_PT:   r_pt   <= pwdata[rtpts_pkg::PT_W-1:0];
                rtpts_pkg::REG_SSRC: r_ssrc <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rtpts_pkg::REG_MTU:  prdata = 32'(r_mtu);
            rtpts_pkg::REG_PT:   prdata = 32'(r_pt);
            rtpts_pkg::REG_SSRC: prdata = r_ssrc;
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg.payload_type = r_pt;
    assign o_cfg.ssrc_id      = r_ssrc;
    assign o_cfg.psize        = r_psize;

endmodule

@@ design/rtpts_engine.sv @@
module rtpts_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtpts_pkg::t_cfg i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_opcode,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_buffer,
    input  logic [31:0]     i_now_ms,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_packet_end,
    output logic            o_run_last
);

    localparam logic [rtpts_pkg::IDX_W-1:0] IDX_FIRST =
        rtpts_pkg::IDX_W'(1);
    localparam logic [rtpts_pkg::IDX_W-1:0] IDX_LAST =
        rtpts_pkg::IDX_W'(rtpts_pkg::HEADER_BYTES - 1);

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;
    logic [31:0] r_in_now;

    rtpts_pkg::t_state r_state, n_state;
    logic [rtpts_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [rtpts_pkg::SEQ_W-1:0] r_seq, n_seq;
    logic [rtpts_pkg::SEQ_W-1:0] r_hdr_seq, n_hdr_seq;
    logic [rtpts_pkg::TS_W-1:0]  r_ts, n_ts;
    logic [31:0]                 r_base, n_base;
    logic [rtpts_pkg::MTU_W-1:0] r_count, n_count;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_pend, n_out_pend;
    logic       r_out_last, n_out_last;

    logic                        out_go;
    logic                        consume;
    logic [31:0]                 base_sel;
    logic [rtpts_pkg::TS_W-1:0]  ts_calc;
    logic [rtpts_pkg::MTU_W-1:0] count_inc;
    logic                        pend;
    logic [rtpts_pkg::HDR_W-1:0] hdr_vec;
    logic [rtpts_pkg::HDR_W-1:0] hdr_sh;

    assign out_go    = !r_out_valid || i_out_ready;
    assign base_sel  = (r_base == 32'd0 || r_in_now < r_base) ? r_in_now : r_base;
    assign ts_calc   = (r_in_now - base_sel) * rtpts_pkg::TS_SCALE;
    assign count_inc = r_count + rtpts_pkg::MTU_W'(1);
    assign pend      = r_in_eob || (count_inc >= i_cfg.psize);
    assign hdr_vec   = {rtpts_pkg::RTP_BYTE0, 1'b0, i_cfg.payload_type, r_hdr_seq,
                        r_ts, i_cfg.ssrc_id};
    assign hdr_sh    = hdr_vec << {r_idx, 3'b000};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_seq       = r_seq;
        n_hdr_seq   = r_hdr_seq;
        n_ts        = r_ts;
        n_base      = r_base;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_pend  = r_out_pend;
        n_out_last  = r_out_last;
        consume     = 1'b0;
        case (r_state)
            rtpts_pkg::ST_READY: begin
                if (r_in_valid) begin
                    if (r_in_op == rtpts_pkg::OP_CLEAR) begin
                        n_base  = 32'd0;
                        consume = 1'b1;
                    end else if (r_count == '0) begin
                        if (out_go) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = rtpts_pkg::RTP_BYTE0;
                            n_out_pend  = 1'b0;
                            n_out_last  = 1'b0;
                            n_base      = (ts_calc == rtpts_pkg::TS_WRAP) ? 32'd0 : base_sel;
                            n_ts        = ts_calc;
                            n_hdr_seq   = r_seq;
                            n_seq       = r_seq + rtpts_pkg::SEQ_W'(1);
                            n_idx       = IDX_FIRST;
                            n_state     = rtpts_pkg::ST_HDR;
                        end
                    end else if (out_go) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = r_in_byte;
                        n_out_pend  = pend;
                        n_out_last  = 1'b1;
                        n_count     = pend ? '0 : count_inc;
                        consume     = 1'b1;
                    end
                end
            end
            rtpts_pkg::ST_HDR: begin
                if (out_go) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = hdr_sh[rtpts_pkg::HDR_W-1 -: 8];
                    n_out_pend  = 1'b0;
                    n_out_last  = 1'b0;
                    if (r_idx == IDX_LAST) begin
                        n_state = rtpts_pkg::ST_PAY;
                    end else begin
                        n_idx = r_idx + rtpts_pkg::IDX_W'(1);
                    end
                end
            end
            rtpts_pkg::ST_PAY: begin
                if (out_go) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_in_byte;
                    n_out_pend  = pend;
                    n_out_last  = 1'b1;
                    n_count     = pend ? '0 : count_inc;
                    consume     = 1'b1;
                    n_state     = rtpts_pkg::ST_READY;
                end
            end
            default: n_state = rtpts_pkg::ST_READY;
        endcase
    end

    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= rtpts_pkg::ST_READY;
            r_idx       <= '0;
            r_seq       <= '0;
            r_base      <= 32'd0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready)
                r_in_valid <= i_in_valid;
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_seq       <= n_seq;
            r_base      <= n_base;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_buffer;
            r_in_now  <= i_now_ms;
        end
        r_hdr_seq  <= n_hdr_seq;
        r_ts       <= n_ts;
        r_out_byte <= n_out_byte;
        r_out_pend <= n_out_pend;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_packet_end = r_out_pend;
    assign o_run_last   = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rtpts_pkg::ST_HDR |-> (r_idx >= IDX_FIRST && r_idx <= IDX_LAST))
        else $error("header index out of range");

    a_hdr_to_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtpts_pkg::ST_HDR && r_idx == IDX_LAST && out_go)
        |=> r_state == rtpts_pkg::ST_PAY)
        else $error("header did not hand over to payload byte");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && n_out_valid && n_out_pend) |=> r_count == '0)
        else $error("payload count not cleared at packet close");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_now)))
        else $error("held input item overwritten");

endmodule

@@ design/rtp_mpegts_packetizer_core.sv @@
// A payload byte passes through the input register, then the output register.
// Throughput: one transport stream byte per cycle within a packet unless i_out_ready
// stalls; the first byte of a packet waits while the single output byte lane carries
// the header. A clear-base item resets the time base and produces no output.
// Reset (synchronous, active low) clears sequence number, time base, payload count
// and restores mtu 1500, payload type 33, ssrc 12; no clearing pass is needed.
module rtp_mpegts_packetizer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtpts_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_end_of_buffer,
    input  logic [31:0]                  i_now_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_out_byte,
    output logic                         o_packet_end,
    output logic                         o_run_last
);

    rtpts_pkg::t_cfg cfg;

    rtpts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rtpts_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_packet_end    (o_packet_end),
        .o_run_last      (o_run_last)
    );

endmodule
